// File: hw/rtl/gefm_pkg.sv
// Shared constants, types and CSR codes for the gradient energy focus measure.
`default_nettype none
package gefm_pkg;

   localparam int PIXEL_W = 8;
   localparam int SCORE_W = 41;
   localparam int CFG_W = 13;
   localparam int SQ_W = 2 * PIXEL_W;
   localparam int ADD_W = SQ_W + 1;

   localparam int MAX_WIDTH_DEF = 4096;
   localparam int MAX_HEIGHT_DEF = 4096;
   localparam int RESET_WIDTH = 640;
   localparam int RESET_HEIGHT = 480;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'd1;

   // per-pixel flags carried from the scan stage to the accumulator
   typedef struct packed {
      logic h_en;
      logic v_en;
      logic last;
   } term_tag_type;

endpackage
`default_nettype wire

// File: hw/rtl/gradient_energy_focus_measure_top.sv
// Top level of the energy-of-gradient focus measure over a raster pixel stream.
//
//  channel  dir  handshake           payload
//  req      in   req_valid/stall     req_pixel        (8 bit)
//  rsp      out  rsp_valid/stall     rsp_focus_score  (41 bit)
//  csr      in   csr_write           csr_index, csr_wdata (13 bit)
//
// One pixel per cycle while no stall is raised; a pixel's terms reach the score
// through the line store read at the accepting edge, then the squaring stage
// and the accumulator add.
// The frame's score includes its last pixel's terms and is held in
// an output register, so pixels of the next frame keep flowing while it waits.
// Only the last pixel of a frame stalls, while the previous score is undelivered.
// Reset is synchronous; the line store is not cleared.
`default_nettype none
module gradient_energy_focus_measure_top #(
   parameter int MAX_WIDTH = gefm_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = gefm_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write,
   input  wire logic [gefm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [gefm_pkg::CFG_W-1:0]     csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [gefm_pkg::PIXEL_W-1:0]   req_pixel,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [gefm_pkg::SCORE_W-1:0]   rsp_focus_score
);
   import gefm_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);

   logic               rd_en;
   logic [COL_W-1:0]   rd_addr;
   logic [PIXEL_W-1:0] rd_data;
   logic               wr_en;
   logic [COL_W-1:0]   wr_addr;
   logic [PIXEL_W-1:0] wr_data;
   logic               s1_valid;
   logic [COL_W-1:0]   s1_addr;
   logic [PIXEL_W-1:0] s1_pixel;
   logic [PIXEL_W-1:0] s1_left;
   term_tag_type       s1_tag;
   logic               result_busy;

   gefm_scan #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .COL_W     (COL_W),
      .ROW_W     (ROW_W)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_pixel  (req_pixel),
      .result_busy(result_busy),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .s1_valid   (s1_valid),
      .s1_addr    (s1_addr),
      .s1_pixel   (s1_pixel),
      .s1_left    (s1_left),
      .s1_tag     (s1_tag)
   );

   gefm_line_ram #(
      .DEPTH (MAX_WIDTH),
      .ADDR_W(COL_W)
   ) u_line_ram (
      .clock  (clock),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

   gefm_accum #(
      .COL_W(COL_W)
   ) u_accum (
      .clock          (clock),
      .reset          (reset),
      .s1_valid       (s1_valid),
      .s1_addr        (s1_addr),
      .s1_pixel       (s1_pixel),
      .s1_left        (s1_left),
      .s1_tag         (s1_tag),
      .above          (rd_data),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .result_busy    (result_busy),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_focus_score(rsp_focus_score)
   );

   // a closing pixel only enters when no other score is pending
   a_single_score: assert property (@(posedge clock) disable iff (reset)
      (s1_valid && s1_tag.last) |-> !result_busy)
      else $error("closing pixel entered with a score pending");

   a_score_latency: assert property (@(posedge clock) disable iff (reset)
      (s1_valid && s1_tag.last) |-> ##2 rsp_valid)
      else $error("score not presented two cycles after closing pixel");

   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid)
      else $error("second score right after a delivered one");

endmodule
`default_nettype wire

// File: hw/rtl/gefm_line_ram.sv
// Single-port-write, single-port-read line store with registered read data.
`default_nettype none
module gefm_line_ram #(
   parameter int DEPTH = gefm_pkg::MAX_WIDTH_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                       clock,
   input  wire logic                       rd_en,
   input  wire logic [ADDR_W-1:0]          rd_addr,
   output logic      [gefm_pkg::PIXEL_W-1:0] rd_data,
   input  wire logic                       wr_en,
   input  wire logic [ADDR_W-1:0]          wr_addr,
   input  wire logic [gefm_pkg::PIXEL_W-1:0] wr_data
);
   import gefm_pkg::*;

   logic [PIXEL_W-1:0] mem [DEPTH];
   logic [PIXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hw/rtl/gefm_scan.sv
// Raster position counters, frame size registers, line store read and input stall.
`default_nettype none
module gefm_scan #(
   parameter int MAX_WIDTH = gefm_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = gefm_pkg::MAX_HEIGHT_DEF,
   parameter int COL_W = $clog2(MAX_WIDTH),
   parameter int ROW_W = $clog2(MAX_HEIGHT)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write,
   input  wire logic [gefm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [gefm_pkg::CFG_W-1:0]     csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [gefm_pkg::PIXEL_W-1:0]   req_pixel,
   input  wire logic                          result_busy,
   output logic                               rd_en,
   output logic      [COL_W-1:0]              rd_addr,
   output logic                               s1_valid,
   output logic      [COL_W-1:0]              s1_addr,
   output logic      [gefm_pkg::PIXEL_W-1:0]   s1_pixel,
   output logic      [gefm_pkg::PIXEL_W-1:0]   s1_left,
   output gefm_pkg::term_tag_type             s1_tag
);
   import gefm_pkg::*;

   // last index in use for a requested size, with the size clamped to [2, maxv]
   function automatic int clamp_last(input int v, input int maxv);
      int r;
      if (v < 2) begin
         r = 1;
      end else if (v > maxv) begin
         r = maxv - 1;
      end else begin
         r = v - 1;
      end
      return r;
   endfunction

   logic [COL_W-1:0]   wlast_ff, wlast_in;
   logic [ROW_W-1:0]   hlast_ff, hlast_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [PIXEL_W-1:0] left_ff;
   logic               s1_valid_ff;
   logic [COL_W-1:0]   s1_addr_ff;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic [PIXEL_W-1:0] s1_left_ff;
   term_tag_type       s1_tag_ff;
   logic               last_col;
   logic               last_row;
   logic               frame_last;
   logic               accept;

   assign last_col = (col_ff >= wlast_ff);
   assign last_row = (row_ff >= hlast_ff);
   assign frame_last = last_col && last_row;
   // one result in flight at most: the closing pixel waits for the previous score
   assign req_stall = frame_last && (result_busy || (s1_valid_ff && s1_tag_ff.last));
   assign accept = req_valid && !req_stall;

   always_comb begin
      wlast_in = wlast_ff;
      hlast_in = hlast_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               wlast_in = COL_W'(clamp_last(int'(csr_wdata), MAX_WIDTH));
            end
            CSR_FRAME_HEIGHT: begin
               hlast_in = ROW_W'(clamp_last(int'(csr_wdata), MAX_HEIGHT));
            end
            default: begin
               wlast_in = wlast_ff;
            end
         endcase
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (!last_col) begin
            col_in = col_ff + COL_W'(1);
         end else begin
            col_in = '0;
            if (!last_row) begin
               row_in = row_ff + ROW_W'(1);
            end else begin
               row_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff <= COL_W'(clamp_last(RESET_WIDTH, MAX_WIDTH));
         hlast_ff <= ROW_W'(clamp_last(RESET_HEIGHT, MAX_HEIGHT));
         col_ff <= '0;
         row_ff <= '0;
         left_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         wlast_ff <= wlast_in;
         hlast_ff <= hlast_in;
         col_ff <= col_in;
         row_ff <= row_in;
         s1_valid_ff <= accept;
         if (accept) begin
            left_ff <= req_pixel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff <= col_ff;
         s1_pixel_ff <= req_pixel;
         s1_left_ff <= left_ff;
         s1_tag_ff.h_en <= (col_ff != '0) && !last_row;
         s1_tag_ff.v_en <= (row_ff != '0) && !last_col;
         s1_tag_ff.last <= frame_last;
      end
   end

   assign rd_en = accept;
   assign rd_addr = col_ff;
   assign s1_valid = s1_valid_ff;
   assign s1_addr = s1_addr_ff;
   assign s1_pixel = s1_pixel_ff;
   assign s1_left = s1_left_ff;
   assign s1_tag = s1_tag_ff;

endmodule
`default_nettype wire

// File: hw/rtl/gefm_accum.sv
// Squared differences, line store write-back, score accumulator and result register.
`default_nettype none
module gefm_accum #(
   parameter int COL_W = $clog2(gefm_pkg::MAX_WIDTH_DEF)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        s1_valid,
   input  wire logic [COL_W-1:0]            s1_addr,
   input  wire logic [gefm_pkg::PIXEL_W-1:0] s1_pixel,
   input  wire logic [gefm_pkg::PIXEL_W-1:0] s1_left,
   input  wire gefm_pkg::term_tag_type      s1_tag,
   input  wire logic [gefm_pkg::PIXEL_W-1:0] above,
   output logic                             wr_en,
   output logic      [COL_W-1:0]            wr_addr,
   output logic      [gefm_pkg::PIXEL_W-1:0] wr_data,
   output logic                             result_busy,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic      [gefm_pkg::SCORE_W-1:0] rsp_focus_score
);
   import gefm_pkg::*;

   logic [PIXEL_W-1:0] dh;
   logic [PIXEL_W-1:0] dv;
   logic [SQ_W-1:0]    sqh;
   logic [SQ_W-1:0]    sqv;
   logic [ADD_W-1:0]   add_in;
   logic [ADD_W-1:0]   add_ff;
   logic               s2_valid_ff;
   logic               s2_last_ff;
   logic [SCORE_W-1:0] sum_ff;
   logic [SCORE_W-1:0] sum_next;
   logic               rsp_valid_ff;
   logic [SCORE_W-1:0] rsp_score_ff;

   assign dh = (s1_pixel >= s1_left) ? (s1_pixel - s1_left) : (s1_left - s1_pixel);
   assign dv = (s1_pixel >= above) ? (s1_pixel - above) : (above - s1_pixel);
   assign sqh = SQ_W'(dh) * SQ_W'(dh);
   assign sqv = SQ_W'(dv) * SQ_W'(dv);
   assign add_in = (s1_tag.h_en ? ADD_W'(sqh) : '0) + (s1_tag.v_en ? ADD_W'(sqv) : '0);

   assign wr_en = s1_valid;
   assign wr_addr = s1_addr;
   assign wr_data = s1_pixel;

   assign sum_next = sum_ff + SCORE_W'(add_ff);

   always_ff @(posedge clock) begin
      add_ff <= add_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s2_last_ff <= 1'b0;
         sum_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid;
         s2_last_ff <= s1_valid && s1_tag.last;
         if (s2_valid_ff && s2_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (s2_valid_ff) begin
            if (s2_last_ff) begin
               sum_ff <= '0;
            end else begin
               sum_ff <= sum_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && s2_last_ff) begin
         rsp_score_ff <= sum_next;
      end
   end

   assign result_busy = s2_last_ff || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_focus_score = rsp_score_ff;

endmodule
`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the energy-of-gradient focus measure top level.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gefm_pkg::*;

   localparam int RESET_CYCLES = 8;
   localparam int SETTLE_CYCLES = 10;
   localparam int DRAIN_CYCLES = 12;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SQUEEZE_CYCLES = 400;
   localparam int SQUEEZE_PHASE = 1;
   localparam int PREFILL_ITEMS = 96;
   localparam int BULK_ITEMS = 1430;
   localparam int MAX_REPORTS = 10;
   localparam int PLAN_LEN = 28;

   typedef enum logic [1:0] {STEP_PIXEL, STEP_SET_WIDTH, STEP_SET_HEIGHT} step_kind_type;
   typedef enum int {TEXTURE_NOISE, TEXTURE_EDGES, TEXTURE_RAMP, TEXTURE_FLAT} texture_type;

   typedef struct packed {
      step_kind_type    kind;
      logic [CFG_W-1:0] value;
      logic             typed;
      logic [SCORE_W-1:0] score;
   } plan_row_type;

   // typed scores only where the frame is 2x2: (b-a)^2 + (c-a)^2
   localparam plan_row_type DIRECTED_PLAN [PLAN_LEN] = '{
      '{STEP_PIXEL, 13'd255, 1'b0, 41'd0},
      '{STEP_PIXEL, 13'd0, 1'b0, 41'd0},
      '{STEP_PIXEL, 13'd255, 1'b0, 41'd0},
      '{STEP_SET_WIDTH, 13'd0, 1'b0, 41'd0},
      '{STEP_SET_HEIGHT, 13'd1, 1'b0, 41'd0},
      '{STEP_PIXEL, 13'd0, 1'b0, 41'd0},
      '{STEP_PIXEL, 13'd128, 1'b0, 41'd0},
      '{STEP_PIXEL, 13'd7, 1'b0, 41'd0},
      '{STEP_PIXEL, 13'd0, 1'b0, 41'd0},
      '{STEP_PIXEL, 13'd255, 1'b0, 41'd0},
      '{STEP_PIXEL, 13'd255, 1'b0, 41'd0},
      '{STEP_PIXEL, 13'd0, 1'b1, 41'd130050},
      '{STEP_PIXEL, 13'd255, 1'b0, 41'd0},
      '{STEP_PIXEL, 13'd255, 1'b0, 41'd0},
      '{STEP_PIXEL, 13'd255, 1'b0, 41'd0},
      '{STEP_PIXEL, 13'd255, 1'b1, 41'd0},
      '{STEP_PIXEL, 13'd0, 1'b0, 41'd0},
      '{STEP_PIXEL, 13'd255, 1'b0, 41'd0},
      '{STEP_PIXEL, 13'd0, 1'b0, 41'd0},
      '{STEP_PIXEL, 13'd255, 1'b1, 41'd65025},
      '{STEP_SET_WIDTH, 13'd3, 1'b0, 41'd0},
      '{STEP_SET_HEIGHT, 13'd2, 1'b0, 41'd0},
      '{STEP_PIXEL, 13'd10, 1'b0, 41'd0},
      '{STEP_PIXEL, 13'd200, 1'b0, 41'd0},
      '{STEP_PIXEL, 13'd30, 1'b0, 41'd0},
      '{STEP_PIXEL, 13'd0, 1'b0, 41'd0},
      '{STEP_PIXEL, 13'd255, 1'b0, 41'd0},
      '{STEP_PIXEL, 13'd128, 1'b0, 41'd0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_FRAME_WIDTH;
   logic [CFG_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [PIXEL_W-1:0] req_pixel = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [SCORE_W-1:0] rsp_focus_score;

   // predictor state
   logic [PIXEL_W-1:0] line_buf [MAX_WIDTH_DEF];
   logic [PIXEL_W-1:0] prev_px = '0;
   int col_idx = 0;
   int row_idx = 0;
   logic [SCORE_W-1:0] energy = '0;
   logic [CFG_W-1:0] cfg_w = CFG_W'(RESET_WIDTH);
   logic [CFG_W-1:0] cfg_h = CFG_W'(RESET_HEIGHT);

   logic [SCORE_W-1:0] pending_scores [$];
   int fault_count = 0;
   int idle_cycles = 0;
   bit tx_steady = 1'b0;
   logic [PIXEL_W-1:0] texture_px = '0;
   logic squeeze_req = 1'b0;
   logic squeeze_done = 1'b0;
   int squeeze_left = 0;
   int rx_hold = 0;
   int rx_free = 0;

   gradient_energy_focus_measure_top DUT (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_pixel(req_pixel),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_focus_score(rsp_focus_score)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return int'(v);
   endfunction

   function automatic int sq_diff(input logic [PIXEL_W-1:0] a, input logic [PIXEL_W-1:0] b);
      int d;
      d = (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
      return d * d;
   endfunction

   function automatic logic [PIXEL_W-1:0] make_pixel(input texture_type style,
                                                     input logic [PIXEL_W-1:0] prior);
      case (style)
         TEXTURE_NOISE: return PIXEL_W'($urandom);
         TEXTURE_EDGES: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         TEXTURE_RAMP: return prior + PIXEL_W'($urandom_range(0, 6)) - 8'd3;
         default: return prior;
      endcase
   endfunction

   // one pixel through the scan: adds the horizontal term of the left
   // neighbour and the vertical term of the pixel above
   task automatic score_pixel(input logic [PIXEL_W-1:0] px, output bit frame_done,
                              output logic [SCORE_W-1:0] score);
      int w;
      int h;
      bit end_col;
      bit end_row;
      logic [PIXEL_W-1:0] above;
      w = clamp_dim(cfg_w, MAX_WIDTH_DEF);
      h = clamp_dim(cfg_h, MAX_HEIGHT_DEF);
      end_col = (col_idx >= w - 1);
      end_row = (row_idx >= h - 1);
      above = (col_idx < MAX_WIDTH_DEF) ? line_buf[col_idx] : '0;
      if (col_idx >= 1 && !end_row) energy = energy + SCORE_W'(sq_diff(px, prev_px));
      if (row_idx >= 1 && !end_col) energy = energy + SCORE_W'(sq_diff(px, above));
      if (col_idx < MAX_WIDTH_DEF) line_buf[col_idx] = px;
      prev_px = px;
      frame_done = 1'b0;
      score = '0;
      if (!end_col) begin
         col_idx++;
      end else begin
         col_idx = 0;
         if (!end_row) begin
            row_idx++;
         end else begin
            frame_done = 1'b1;
            score = energy;
            energy = '0;
            row_idx = 0;
         end
      end
   endtask

   task automatic push_pixel(input logic [PIXEL_W-1:0] px, input logic typed,
                             input logic [SCORE_W-1:0] typed_score);
      int gap;
      bit done;
      logic [SCORE_W-1:0] predicted;
      gap = tx_steady ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      score_pixel(px, done, predicted);
      if (done) pending_scores = {pending_scores, (typed ? typed_score : predicted)};
   endtask

   // block must be idle: no score owed and the pipeline drained
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      req_valid <= 1'b0;
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_FRAME_WIDTH) cfg_w = val;
      else cfg_h = val;
   endtask

   task automatic stream_pixels(input int count, input int area);
      texture_type style;
      style = TEXTURE_NOISE;
      for (int n = 0; n < count; n++) begin
         if (n % area == 0) style = texture_type'($urandom_range(0, 3));
         texture_px = make_pixel(style, texture_px);
         push_pixel(texture_px, 1'b0, '0);
      end
   endtask

   task automatic note_fault(input string what);
      fault_count++;
      if (fault_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, what);
   endtask

   // receiver: random stall runs, long free stretches, one long hold-off
   always @(posedge clock) begin
      if (squeeze_req && !squeeze_done) begin
         squeeze_done <= 1'b1;
         squeeze_left = SQUEEZE_CYCLES;
      end
      if (squeeze_left > 0) begin
         squeeze_left--;
         rsp_stall <= 1'b1;
      end else if (rx_hold > 0) begin
         rx_hold--;
         rsp_stall <= 1'b1;
      end else if (rx_free > 0) begin
         rx_free--;
         rsp_stall <= 1'b0;
      end else begin
         rx_hold = idle_len();
         rx_free = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                               : $urandom_range(0, 6);
         rsp_stall <= (rx_hold > 0);
         if (rx_hold > 0) rx_hold--;
      end
   end

   always @(posedge clock) begin
      logic [SCORE_W-1:0] want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (pending_scores.size() == 0) begin
               note_fault($sformatf("score %0d with no frame owed", rsp_focus_score));
            end else begin
               want = pending_scores.pop_front();
               if (rsp_focus_score !== want)
                  note_fault($sformatf("focus_score expected %0d, got %0d",
                                       want, rsp_focus_score));
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      logic [CFG_W-1:0] w_val;
      logic [CFG_W-1:0] h_val;
      int area;
      int count;
      int frames;
      int phase;
      int bulk_sent;
      int roll;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < PLAN_LEN; k++) begin
         case (DIRECTED_PLAN[k].kind)
            STEP_SET_WIDTH: write_reg(CSR_FRAME_WIDTH, DIRECTED_PLAN[k].value);
            STEP_SET_HEIGHT: write_reg(CSR_FRAME_HEIGHT, DIRECTED_PLAN[k].value);
            default: push_pixel(DIRECTED_PLAN[k].value[PIXEL_W-1:0], DIRECTED_PLAN[k].typed,
                                DIRECTED_PLAN[k].score);
         endcase
      end

      // oversized width cut short: fills the line store entries the random frames use
      write_reg(CSR_FRAME_WIDTH, '1);
      write_reg(CSR_FRAME_HEIGHT, '0);
      stream_pixels(PREFILL_ITEMS, PREFILL_ITEMS);

      bulk_sent = 0;
      phase = 0;
      while (bulk_sent < BULK_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (phase == SQUEEZE_PHASE) begin
            w_val = CFG_W'(2);
            h_val = CFG_W'(2);
         end else if (roll < 70) begin
            w_val = CFG_W'($urandom_range(2, 12));
            h_val = CFG_W'($urandom_range(2, 6));
         end else if (roll < 80) begin
            w_val = CFG_W'($urandom_range(0, 2));
            h_val = CFG_W'($urandom_range(0, 2));
         end else if (roll < 95) begin
            w_val = CFG_W'($urandom_range(13, 80));
            h_val = CFG_W'($urandom_range(2, 3));
         end else begin
            w_val = CFG_W'($urandom_range(2, 4));
            h_val = CFG_W'($urandom_range(20, 60));
         end
         write_reg(CSR_FRAME_WIDTH, w_val);
         write_reg(CSR_FRAME_HEIGHT, h_val);
         area = clamp_dim(w_val, MAX_WIDTH_DEF) * clamp_dim(h_val, MAX_HEIGHT_DEF);
         if (phase == SQUEEZE_PHASE) begin
            tx_steady = 1'b1;
            frames = 16;
            squeeze_req <= 1'b1;
         end else begin
            tx_steady = ($urandom_range(0, 3) == 0);
            frames = $urandom_range(1, 4);
         end
         count = frames * area;
         // stop part-way through a frame so the next sizes land mid-frame
         if (phase != SQUEEZE_PHASE && $urandom_range(0, 4) == 0)
            count = count - $urandom_range(1, area - 1);
         if (count > BULK_ITEMS - bulk_sent) count = BULK_ITEMS - bulk_sent;
         stream_pixels(count, area);
         bulk_sent += count;
         phase++;
      end

      req_valid <= 1'b0;
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
